/* hw/rtl/tmhd_pkg.sv */
// Package for the time-of-flight delta-t block: field widths and the saturation helper.
// Used by the serial square root, the serial divider and the top level.
`default_nettype none
package tmhd_pkg;

  localparam int unsigned SQ_IN_W   = 42;  // radicand, even width
  localparam int unsigned SQ_OUT_W  = 21;  // rounded root
  localparam int unsigned DIV_NUM_W = 60;  // numerator and quotient
  localparam int unsigned DIV_DEN_W = 42;  // denominator
  localparam int unsigned NUM_MASS  = 4;

  localparam logic [2:0] REG_MASS_E = 3'd0;
  localparam logic [2:0] REG_MASS_P = 3'd1;
  localparam logic [2:0] REG_MASS_PI = 3'd2;
  localparam logic [2:0] REG_MASS_K = 3'd3;
  localparam logic [2:0] REG_LIGHT  = 3'd4;

  // Clamp a 36-bit signed value to signed 32 bits.
  function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/tof_mass_hypothesis_delta_t.sv */
// Time-of-flight particle identification: reference vertex and four mass-hypothesis delta times.
// A reference item runs one pass of the serial divider.
// A track item runs, per hypothesis, the mass-squared and path-energy products on the shared 22x22
// multiplier, the serial square root and the serial divider; a track with zero momentum skips them all.
// One item at a time; the next is taken once the result is in the output register.
// Synchronous reset clears the vertex to zero and loads the default masses and light speed.
`default_nettype none
module tof_mass_hypothesis_delta_t import tmhd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [71:0]  s_tdata,   // hit_time[31:0], path_length[49:32], momentum[69:50]
  input  wire logic [0:0]   s_tuser,   // command
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [159:0]      m_tdata,   // ref_vertex, dt_electron, dt_proton, dt_pion, dt_kaon
  output logic [0:0]        m_tuser,   // status
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [21:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_REF, S_MPC, S_MPP, S_MMM, S_SQ0, S_SQW, S_MRE, S_MRW, S_DIV0, S_DIVW,
    S_ACC, S_DONE
  } state_t;

  state_t state;

  logic [16:0] mass [NUM_MASS];
  logic [21:0] light;
  logic signed [31:0] vertex;

  logic        cmd;
  logic signed [31:0] t_in;
  logic [17:0] r_in;
  logic [19:0] p_in;
  logic [1:0]  idx;
  logic        stat;
  logic signed [31:0] dts [NUM_MASS];

  logic [21:0] mul_a, mul_b;
  logic [43:0] prod;
  logic [41:0] pc;
  logic [40:0] pp;
  logic [20:0] energy;

  logic        sq_start, sq_done, div_start, div_done;
  logic [SQ_IN_W-1:0]   sq_x;
  logic [SQ_OUT_W-1:0]  sq_root;
  logic [DIV_NUM_W-1:0] div_num, quot;
  logic [DIV_DEN_W-1:0] div_den;
  logic [21:0] c_eff;

  assign c_eff = (light == '0) ? 22'd1 : light;

  // The path-energy product is driven in both S_MRE and S_MRW so that it is still there at divider start.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MPC:        begin mul_a = 22'(p_in); mul_b = c_eff; end
      S_MPP:        begin mul_a = 22'(p_in); mul_b = 22'(p_in); end
      S_MMM:        begin mul_a = 22'(mass[idx]); mul_b = 22'(mass[idx]); end
      S_MRE, S_MRW: begin mul_a = 22'(r_in); mul_b = 22'(energy); end
      default:      begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign sq_start  = (state == S_SQ0);
  assign sq_x      = SQ_IN_W'(pp) + SQ_IN_W'(prod);
  assign div_start = (state == S_REF) || (state == S_DIV0);

  always_comb begin
    if (state == S_REF) begin
      div_num = DIV_NUM_W'({r_in, 20'd0}) + DIV_NUM_W'(c_eff >> 1);
      div_den = DIV_DEN_W'(c_eff);
    end else begin
      div_num = DIV_NUM_W'({prod[38:0], 20'd0}) + DIV_NUM_W'(pc >> 1);
      div_den = pc;
    end
  end

  tmhd_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_x), .done(sq_done), .root(sq_root)
  );

  tmhd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(quot)
  );

  logic signed [35:0] trk_sum, ref_sum;
  assign trk_sum = 36'(vertex) - 36'(t_in) + $signed({2'b00, quot[33:0]});
  assign ref_sum = 36'(t_in) - $signed({3'b000, quot[32:0]});

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      vertex   <= '0;
      mass[0]  <= 17'd33;
      mass[1]  <= 17'd61491;
      mass[2]  <= 17'd9147;
      mass[3]  <= 17'd32354;
      light    <= 22'd1964696;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_MASS_E:  mass[0] <= cfg_data[16:0];
          REG_MASS_P:  mass[1] <= cfg_data[16:0];
          REG_MASS_PI: mass[2] <= cfg_data[16:0];
          REG_MASS_K:  mass[3] <= cfg_data[16:0];
          REG_LIGHT:   light   <= cfg_data;
          default:     ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd  <= s_tuser[0];
            t_in <= s_tdata[31:0];
            r_in <= s_tdata[49:32];
            p_in <= s_tdata[69:50];
            idx  <= '0;
            stat <= s_tuser[0] && (s_tdata[69:50] == '0);
            for (int i = 0; i < NUM_MASS; i++) dts[i] <= '0;
            if (!s_tuser[0]) begin
              state <= S_REF;
            end else if (s_tdata[69:50] == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_MPC;
            end
          end
        end
        S_REF:  state <= S_DIVW;
        S_MPC:  state <= S_MPP;
        S_MPP: begin
          pc    <= prod[41:0];
          state <= S_MMM;
        end
        S_MMM: begin
          if (idx == 2'd0) pp <= prod[40:0];
          state <= S_SQ0;
        end
        S_SQ0:  state <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            energy <= sq_root;
            state  <= S_MRE;
          end
        end
        S_MRE:  state <= S_MRW;
        S_MRW:  state <= S_DIV0;
        S_DIV0: state <= S_DIVW;
        S_DIVW: if (div_done) state <= S_ACC;
        S_ACC: begin
          if (!cmd) begin
            vertex <= (quot[59:33] != '0) ? 32'sh80000000 : sat36(ref_sum);
            state  <= S_DONE;
          end else begin
            dts[idx] <= (quot[59:34] != '0) ? 32'sh7fffffff : sat36(trk_sum);
            idx      <= idx + 2'd1;
            state    <= (idx == 2'(NUM_MASS - 1)) ? S_DONE : S_MMM;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {dts[3], dts[2], dts[1], dts[0], vertex};
            m_tuser  <= stat;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tmhd_sqrt.sv */
// Bit-serial integer square root, two radicand bits per cycle, rounded to nearest.
// Depends on tmhd_pkg for its widths.
`default_nettype none
module tmhd_sqrt import tmhd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [SQ_IN_W-1:0]    radicand,
  output logic                       done,
  output logic [SQ_OUT_W-1:0]        root
);

  localparam int unsigned REM_W = SQ_OUT_W + 3;

  logic [SQ_IN_W-1:0]  x_sr;
  logic [SQ_OUT_W-1:0] acc;
  logic [REM_W-1:0]    rem;
  logic [4:0]          cnt;
  logic                busy;

  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                fits;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], x_sr[SQ_IN_W-1 -: 2]};
    trial  = {1'b0, acc, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        x_sr <= radicand;
        acc  <= '0;
        rem  <= '0;
        cnt  <= 5'(SQ_OUT_W - 1);
      end else if (busy) begin
        x_sr <= {x_sr[SQ_IN_W-3:0], 2'b00};
        if (fits) begin
          rem <= rem_sh - trial;
          acc <= {acc[SQ_OUT_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          acc <= {acc[SQ_OUT_W-2:0], 1'b0};
        end
        if (cnt == 5'd0) begin
          busy <= 1'b0;
        end
        done <= (cnt == 5'd0);
        cnt  <= cnt - 5'd1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  // Round up when the remainder exceeds the root.
  assign root = (rem > REM_W'(acc)) ? acc + 1'b1 : acc;

endmodule
`default_nettype wire

/* hw/rtl/tmhd_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tmhd_pkg for its widths.
`default_nettype none
module tmhd_div import tmhd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIV_NUM_W-1:0]  num,
  input  wire logic [DIV_DEN_W-1:0]  den,
  output logic                       done,
  output logic [DIV_NUM_W-1:0]       quot
);

  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_DEN_W-1:0] rem;
  logic [5:0]           cnt;
  logic                 busy;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  always_comb begin
    rem_sh = {rem, quot[DIV_NUM_W-1]};
    fits   = (rem_sh >= {1'b0, den_q});
  end

  // The quotient register doubles as the numerator shift register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy  <= 1'b1;
        done  <= 1'b0;
        quot  <= num;
        den_q <= den;
        rem   <= '0;
        cnt   <= 6'(DIV_NUM_W - 1);
      end else if (busy) begin
        if (fits) begin
          rem <= DIV_DEN_W'(rem_sh - {1'b0, den_q});
        end else begin
          rem <= rem_sh[DIV_DEN_W-1:0];
        end
        quot <= {quot[DIV_NUM_W-2:0], fits};
        if (cnt == 6'd0) begin
          busy <= 1'b0;
        end
        done <= (cnt == 6'd0);
        cnt  <= cnt - 6'd1;
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for tof_mass_hypothesis_delta_t: reference and track items, register
// settings and saturation, checked against an in-bench predictor of the delta times.
// Depends on tmhd_pkg and the top level tof_mass_hypothesis_delta_t.
`default_nettype none
module testbench;
  import tmhd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_REFERENCE = 1'b0;
  localparam logic CMD_TRACK     = 1'b1;
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_MOMENTUM = 1'b1;
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;
  localparam logic [16:0] MASS_E_DEFAULT  = 17'd33;
  localparam logic [16:0] MASS_P_DEFAULT  = 17'd61491;
  localparam logic [16:0] MASS_PI_DEFAULT = 17'd9147;
  localparam logic [16:0] MASS_K_DEFAULT  = 17'd32354;
  localparam logic [21:0] LIGHT_DEFAULT   = 22'd1964696;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic signed [31:0] vertex;
    logic signed [31:0] dt_e;
    logic signed [31:0] dt_p;
    logic signed [31:0] dt_pi;
    logic signed [31:0] dt_k;
    logic               status;
  } tof_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;   // hit_time[31:0], path_length[49:32], momentum[69:50]
  logic [0:0]   s_tuser = '0;   // command
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;        // ref_vertex, dt_electron, dt_proton, dt_pion, dt_kaon
  logic [0:0]   m_tuser;        // status
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [21:0]  cfg_data = '0;

  tof_mass_hypothesis_delta_t i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: masses, light speed and stored vertex as the block should hold them.
  logic [16:0]        mass_model [NUM_MASS];
  logic [21:0]        light_model;
  logic signed [31:0] vertex_model;
  tof_result_t        expected_results [$];
  int                 error_count = 0;
  int                 burst_left = 0;
  int                 stall_count = 0;
  int unsigned        cycle_count = 0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned root_nearest(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned step = 64'h4000_0000_0000_0000;
    longint unsigned rem = x;
    while (step > rem) step >>= 2;
    while (step != 0) begin
      if (rem >= res + step) begin
        rem -= res + step;
        res = (res >> 1) + step;
      end else begin
        res >>= 1;
      end
      step >>= 2;
    end
    if (rem > res) res += 1;
    return res;
  endfunction

  function automatic tof_result_t predict_delta_times(logic cmd, logic signed [31:0] t,
                                                      logic [17:0] r, logic [19:0] p);
    tof_result_t res;
    longint unsigned c, rnum, e, q, den;
    logic signed [31:0] dts [NUM_MASS];
    c = (light_model == 0) ? 64'd1 : 64'(light_model);
    rnum = 64'(r) << 20;
    res.status = STATUS_OK;
    for (int i = 0; i < NUM_MASS; i++) dts[i] = '0;
    if (cmd == CMD_REFERENCE) begin
      q = (rnum + c / 2) / c;
      vertex_model = clamp32(longint'(t) - longint'(q));
    end else if (p == 0) begin
      res.status = STATUS_NO_MOMENTUM;
    end else begin
      for (int i = 0; i < NUM_MASS; i++) begin
        e = root_nearest(64'(p) * 64'(p) + 64'(mass_model[i]) * 64'(mass_model[i]));
        den = 64'(p) * c;
        q = (rnum * e + den / 2) / den;
        dts[i] = clamp32(longint'(vertex_model) - longint'(t) + longint'(q));
      end
    end
    res.vertex = vertex_model;
    res.dt_e = dts[0];
    res.dt_p = dts[1];
    res.dt_pi = dts[2];
    res.dt_k = dts[3];
    return res;
  endfunction

  task automatic send_item(logic cmd, logic signed [31:0] t, logic [17:0] r, logic [19:0] p);
    if (burst_left == 0) begin
      // Some bursts follow straight on, so back-to-back items occur too.
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, p, r, t};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(predict_delta_times(cmd, t, r, p));
    burst_left--;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Each write drops the write enable again before the next can start.
  task automatic write_register(logic [2:0] index, logic [21:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (index)
      REG_MASS_E:  mass_model[0] = value[16:0];
      REG_MASS_P:  mass_model[1] = value[16:0];
      REG_MASS_PI: mass_model[2] = value[16:0];
      REG_MASS_K:  mass_model[3] = value[16:0];
      REG_LIGHT:   light_model = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_defaults();
    wait_idle();
    write_register(REG_MASS_E, 22'(MASS_E_DEFAULT));
    write_register(REG_MASS_P, 22'(MASS_P_DEFAULT));
    write_register(REG_MASS_PI, 22'(MASS_PI_DEFAULT));
    write_register(REG_MASS_K, 22'(MASS_K_DEFAULT));
    write_register(REG_LIGHT, LIGHT_DEFAULT);
  endtask

  task automatic test_reference_items();
    send_item(CMD_REFERENCE, 32'sd0, 18'd0, 20'd0);
    send_item(CMD_REFERENCE, 32'sh7fffffff, 18'd0, 20'hfffff);
    send_item(CMD_REFERENCE, 32'sh80000000, 18'h3ffff, 20'd0);
    send_item(CMD_REFERENCE, 32'sd123456, 18'd6400, 20'd0);
  endtask

  task automatic test_track_items();
    send_item(CMD_TRACK, 32'sd1000, 18'd6400, 20'd0);
    send_item(CMD_TRACK, 32'sd0, 18'h3ffff, 20'd1);
    send_item(CMD_TRACK, 32'sh7fffffff, 18'h3ffff, 20'hfffff);
    send_item(CMD_TRACK, 32'sh80000000, 18'd0, 20'd65536);
    // Minimum vertex against maximum hit time drives the deltas to the negative limit.
    send_item(CMD_REFERENCE, 32'sh80000000, 18'h3ffff, 20'd0);
    send_item(CMD_TRACK, 32'sh7fffffff, 18'd1, 20'hfffff);
    send_item(CMD_REFERENCE, 32'sh7fffffff, 18'd0, 20'd0);
    send_item(CMD_TRACK, 32'sh80000000, 18'h3ffff, 20'd1);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_register(REG_LIGHT, 22'd0);            // a zero light speed acts as one
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      write_register(3'(i), 22'($urandom()));    // unused indexes must change nothing
    send_item(CMD_REFERENCE, 32'sd5000, 18'd1, 20'd0);
    send_item(CMD_TRACK, 32'sd5000, 18'd1, 20'd1);
    wait_idle();
    write_register(REG_LIGHT, 22'd1);
    write_register(REG_MASS_E, 22'd0);
    write_register(REG_MASS_P, 22'h3fffff);      // upper bits beyond the mass width drop
    write_register(REG_MASS_PI, 22'd131071);
    write_register(REG_MASS_K, 22'd1);
    send_item(CMD_REFERENCE, 32'sd0, 18'd100, 20'd0);
    send_item(CMD_TRACK, 32'sd0, 18'h3ffff, 20'hfffff);
    wait_idle();
    write_register(REG_LIGHT, 22'h3fffff);
    write_register(REG_MASS_E, 22'd131071);
    write_register(REG_MASS_P, 22'd0);
    send_item(CMD_REFERENCE, 32'sd0, 18'h3ffff, 20'd0);
    send_item(CMD_TRACK, 32'sh80000000, 18'h3ffff, 20'd1);
    send_item(CMD_TRACK, 32'sd77, 18'd3, 20'hfffff);
  endtask

  task automatic test_random_items(int count);
    logic cmd;
    logic signed [31:0] t;
    logic [19:0] p;
    for (int n = 0; n < count; n++) begin
      cmd = ($urandom_range(0, 3) == 0) ? CMD_REFERENCE : CMD_TRACK;
      t = ($urandom_range(0, 1) == 0) ? 32'($urandom()) : 32'($urandom_range(0, 200000)) - 100000;
      case ($urandom_range(0, 19))
        0:       p = 20'd0;
        1, 2, 3: p = 20'($urandom_range(1, 1023));
        default: p = 20'($urandom());
      endcase
      send_item(cmd, t, 18'($urandom()), p);
    end
  endtask

  task automatic randomise_registers();
    wait_idle();
    for (int i = 0; i < NUM_MASS; i++) write_register(3'(i), 22'($urandom()));
    write_register(REG_LIGHT, ($urandom_range(0, 3) == 0) ? 22'($urandom_range(0, 4096))
                                                          : 22'($urandom()));
  endtask

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    tof_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation: tdata %h tuser %b", m_tdata, m_tuser);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[31:0] !== want.vertex) begin
          $error("ref_vertex expected %0d actual %0d", want.vertex, $signed(m_tdata[31:0]));
          error_count++;
        end
        if (m_tdata[63:32] !== want.dt_e) begin
          $error("dt_electron expected %0d actual %0d", want.dt_e, $signed(m_tdata[63:32]));
          error_count++;
        end
        if (m_tdata[95:64] !== want.dt_p) begin
          $error("dt_proton expected %0d actual %0d", want.dt_p, $signed(m_tdata[95:64]));
          error_count++;
        end
        if (m_tdata[127:96] !== want.dt_pi) begin
          $error("dt_pion expected %0d actual %0d", want.dt_pi, $signed(m_tdata[127:96]));
          error_count++;
        end
        if (m_tdata[159:128] !== want.dt_k) begin
          $error("dt_kaon expected %0d actual %0d", want.dt_k, $signed(m_tdata[159:128]));
          error_count++;
        end
        if (m_tuser[0] !== want.status) begin
          $error("status expected %0b actual %0b", want.status, m_tuser[0]);
          error_count++;
        end
      end
    end
  end

  // Receiver stalls: the pattern changes with bits 10 and 9 of the cycle counter, including a phase with no stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case (cycle_count[10:9])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= (cycle_count[2:0] != 3'd0);
      default: m_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("tof_mass_hypothesis_delta_t verification failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    mass_model[0] = MASS_E_DEFAULT;
    mass_model[1] = MASS_P_DEFAULT;
    mass_model[2] = MASS_PI_DEFAULT;
    mass_model[3] = MASS_K_DEFAULT;
    light_model = LIGHT_DEFAULT;
    vertex_model = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reference_items();
    test_track_items();
    test_register_extremes();
    load_defaults();
    test_random_items(250);
    for (int phase = 0; phase < 3; phase++) begin
      randomise_registers();
      test_random_items(250);
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tof_mass_hypothesis_delta_t verification clean");
    end else begin
      $display("tof_mass_hypothesis_delta_t verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/tmhd_pkg.sv
hw/rtl/tmhd_sqrt.sv
hw/rtl/tmhd_div.sv
hw/rtl/tof_mass_hypothesis_delta_t.sv
verif/testbench.sv
